/* sv/gtl_pkg.sv */
// ----------------------------------------------------------------------------
// gtl_pkg
// shared types, character codes and the greek letter table
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int unsigned MAX_CHARS = 4;

  localparam logic [7:0] TABLE_LOW  = 8'd182;
  localparam logic [7:0] TABLE_HIGH = 8'd254;
  localparam logic [7:0] QUOTE_A    = 8'd192;
  localparam logic [7:0] QUOTE_B    = 8'd224;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_NONE    = 8'h00;

  // letters held back for the mp / nt fusion
  typedef enum logic [2:0] {
    HELD_NONE,
    HELD_M_LC,
    HELD_M_UC,
    HELD_N_LC,
    HELD_N_UC
  } gtl_held_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } gtl_map_t;

  // one queue entry: the characters of one item, lowest slot first
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                count;
  } gtl_entry_t;

  typedef struct packed {
    logic       valid;
    gtl_entry_t entry;
  } gtl_push_t;

  typedef struct packed {
    logic       valid;
    gtl_entry_t entry;
  } gtl_head_t;

  function automatic gtl_map_t gtl_map(input logic [7:0] b);
    gtl_map_t m;
    m.second = CH_NONE;
    case (b)
      8'd182: begin m.first = CH_APOS; m.second = "A"; end
      8'd183: m.first = ".";
      8'd184: begin m.first = CH_APOS; m.second = "E"; end
      8'd185: begin m.first = CH_APOS; m.second = "H"; end
      8'd186: begin m.first = CH_APOS; m.second = "I"; end
      8'd187: m.first = 8'd187;
      8'd188: begin m.first = CH_APOS; m.second = "O"; end
      8'd189: m.first = 8'd189;
      8'd190: begin m.first = CH_APOS; m.second = "Y"; end
      8'd191: begin m.first = CH_APOS; m.second = "W"; end
      8'd192: begin m.first = "i"; m.second = CH_APOS; end
      8'd193: m.first = "A";
      8'd194: m.first = "V";
      8'd195: m.first = "G";
      8'd196: m.first = "D";
      8'd197: m.first = "E";
      8'd198: m.first = "Z";
      8'd199: m.first = "H";
      8'd200: m.first = "8";
      8'd201: m.first = "I";
      8'd202: m.first = "K";
      8'd203: m.first = "L";
      8'd204: m.first = "M";
      8'd205: m.first = "N";
      8'd206: begin m.first = "K"; m.second = "S"; end
      8'd207: m.first = "O";
      8'd208: m.first = "P";
      8'd209: m.first = "R";
      8'd210: m.first = 8'd210;
      8'd211: m.first = "S";
      8'd212: m.first = "T";
      8'd213: m.first = "Y";
      8'd214: m.first = "F";
      8'd215: m.first = "X";
      8'd216: begin m.first = "P"; m.second = "S"; end
      8'd217: m.first = "W";
      8'd218: begin m.first = "I"; m.second = CH_QUOTE; end
      8'd219: begin m.first = "Y"; m.second = CH_QUOTE; end
      8'd220: begin m.first = "a"; m.second = CH_APOS; end
      8'd221: begin m.first = "e"; m.second = CH_APOS; end
      8'd222: begin m.first = "h"; m.second = CH_APOS; end
      8'd223: begin m.first = "i"; m.second = CH_APOS; end
      8'd224: begin m.first = "y"; m.second = CH_APOS; end
      8'd225: m.first = "a";
      8'd226: m.first = "v";
      8'd227: m.first = "g";
      8'd228: m.first = "d";
      8'd229: m.first = "e";
      8'd230: m.first = "z";
      8'd231: m.first = "h";
      8'd232: m.first = "8";
      8'd233: m.first = "i";
      8'd234: m.first = "k";
      8'd235: m.first = "l";
      8'd236: m.first = "m";
      8'd237: m.first = "n";
      8'd238: begin m.first = "k"; m.second = "s"; end
      8'd239: m.first = "o";
      8'd240: m.first = "p";
      8'd241: m.first = "r";
      8'd242: m.first = "s";
      8'd243: m.first = "s";
      8'd244: m.first = "t";
      8'd245: m.first = "y";
      8'd246: m.first = "f";
      8'd247: m.first = "x";
      8'd248: begin m.first = "p"; m.second = "s"; end
      8'd249: m.first = "w";
      8'd250: begin m.first = "i"; m.second = CH_QUOTE; end
      8'd251: begin m.first = "y"; m.second = CH_QUOTE; end
      8'd252: begin m.first = "o"; m.second = CH_APOS; end
      8'd253: begin m.first = "y"; m.second = CH_APOS; end
      8'd254: begin m.first = "w"; m.second = CH_APOS; end
      default: m.first = b;
    endcase
    return m;
  endfunction

endpackage

/* sv/gtl_front.sv */
// ----------------------------------------------------------------------------
// gtl_front
// accepts bytes, tracks the held letter and builds the characters of each item
// ----------------------------------------------------------------------------
module gtl_front
  import gtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  input  logic       q_full,
  output gtl_push_t  push
);

  gtl_held_t  held;
  gtl_held_t  held_next;
  gtl_held_t  new_code;
  gtl_map_t   map;
  logic [7:0] held_char;
  logic [7:0] fused;
  logic [7:0] eos_char;
  logic       in_table;
  logic       is_p;
  logic       is_t;
  logic [MAX_CHARS-1:0][7:0] chars;
  logic [2:0] n;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign map      = gtl_map(in_byte);
  assign in_table = (in_byte >= TABLE_LOW) && (in_byte <= TABLE_HIGH);
  assign is_p     = (map.first == "p") || (map.first == "P");
  assign is_t     = (map.first == "t") || (map.first == "T");

  always_comb begin
    unique case (held)
      HELD_M_LC: held_char = "m";
      HELD_M_UC: held_char = "M";
      HELD_N_LC: held_char = "n";
      HELD_N_UC: held_char = "N";
      default:   held_char = CH_NONE;
    endcase
  end

  always_comb begin
    fused = CH_NONE;
    if (is_p && held == HELD_M_LC) begin
      fused = "b";
    end else if (is_p && held == HELD_M_UC) begin
      fused = "B";
    end else if (is_t && held == HELD_N_LC) begin
      fused = "d";
    end else if (is_t && held == HELD_N_UC) begin
      fused = "D";
    end
  end

  always_comb begin
    case (map.first)
      "m":     new_code = HELD_M_LC;
      "M":     new_code = HELD_M_UC;
      "n":     new_code = HELD_N_LC;
      "N":     new_code = HELD_N_UC;
      default: new_code = HELD_NONE;
    endcase
  end

  // list build: at most four appends in a fixed order
  always_comb begin
    chars     = '0;
    n         = 3'd0;
    held_next = HELD_NONE;
    eos_char  = CH_NONE;
    if (in_table) begin
      if (fused != CH_NONE) begin
        chars[n[1:0]] = fused;
        n = n + 3'd1;
        if (map.second != CH_NONE) begin
          chars[n[1:0]] = map.second;
          n = n + 3'd1;
        end
      end else begin
        if (held != HELD_NONE) begin
          chars[n[1:0]] = held_char;
          n = n + 3'd1;
        end
        held_next = new_code;
        if (new_code == HELD_NONE) begin
          chars[n[1:0]] = map.first;
          n = n + 3'd1;
          if (map.second != CH_NONE) begin
            chars[n[1:0]] = map.second;
            n = n + 3'd1;
          end
          if (in_byte == QUOTE_A || in_byte == QUOTE_B) begin
            chars[n[1:0]] = CH_QUOTE;
            n = n + 3'd1;
          end
        end
      end
    end else begin
      if (held != HELD_NONE) begin
        chars[n[1:0]] = held_char;
        n = n + 3'd1;
      end
      chars[n[1:0]] = in_byte;
      n = n + 3'd1;
    end
    // flush on end of stream
    if (in_eos) begin
      unique case (held_next)
        HELD_M_LC: eos_char = "m";
        HELD_M_UC: eos_char = "M";
        HELD_N_LC: eos_char = "n";
        HELD_N_UC: eos_char = "N";
        default:   eos_char = CH_NONE;
      endcase
      if (held_next != HELD_NONE) begin
        chars[n[1:0]] = eos_char;
        n = n + 3'd1;
      end
      held_next = HELD_NONE;
    end
  end

  assign push.valid       = accept && (n != 3'd0);
  assign push.entry.chars = chars;
  assign push.entry.count = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= HELD_NONE;
    end else if (accept) begin
      held <= held_next;
    end
  end

  // every pushed entry carries one to four characters
  assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (push.entry.count != 3'd0) && (push.entry.count <= 3'd4))
    else $error("gtl_front: bad character count");

endmodule

/* sv/gtl_queue.sv */
// ----------------------------------------------------------------------------
// gtl_queue
// short register queue between the front and the back
// ----------------------------------------------------------------------------
module gtl_queue
  import gtl_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  gtl_push_t push,
  output logic      full,
  output gtl_head_t head,
  input  logic      pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  gtl_entry_t    store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] used;
  logic          do_push;
  logic          do_pop;

  assign full       = (used == FULL_CNT);
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (used != '0);
  assign head.valid = (used != '0);
  assign head.entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + CW'(1);
      end else if (do_pop && !do_push) begin
        used <= used - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) used <= FULL_CNT)
    else $error("gtl_queue: occupancy beyond depth");

  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("gtl_queue: pop while empty");

  assert property (@(posedge clk) disable iff (rst) push.valid |-> !full)
    else $error("gtl_queue: push while full");

endmodule

/* sv/gtl_back.sv */
// ----------------------------------------------------------------------------
// gtl_back
// walks the characters of the head entry, one output beat each
// ----------------------------------------------------------------------------
module gtl_back
  import gtl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  gtl_head_t  head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic [1:0] idx;
  logic       beat;

  assign out_valid = head.valid;
  assign out_char  = head.entry.chars[idx];
  assign out_last  = ({1'b0, idx} == (head.entry.count - 3'd1));
  assign beat      = out_valid && out_ready;
  assign pop       = beat && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (beat) begin
      idx <= out_last ? 2'd0 : idx + 2'd1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    head.valid |-> ({1'b0, idx} < head.entry.count))
    else $error("gtl_back: slot index past entry count");

endmodule

/* sv/greek_to_latin_transliterator_unit.sv */
// ----------------------------------------------------------------------------
// greek_to_latin_transliterator_unit
// iso-8859-7 greek bytes to latin characters, with mp/nt fusion
// ----------------------------------------------------------------------------
// an item is registered in the queue before its first character is offered
// throughput: one input beat per cycle while m_tready is high and items give
//   at most one character; k characters take k beats, the queue absorbs them
// reset: clears the held letter, empties the queue and the character index
// ----------------------------------------------------------------------------
module greek_to_latin_transliterator_unit
  import gtl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // last_of_run
);

  gtl_push_t push;
  gtl_head_t head;
  logic      q_full;
  logic      pop;

  // front: classify the byte, fuse or hold letters, build the character list
  gtl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_eos   (s_tlast),
    .q_full   (q_full),
    .push     (push)
  );

  // queue: items that produce no characters never enter it
  gtl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // back: one character per output beat, tlast on the final one of an item
  gtl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

/* tb/greek_to_latin_transliterator_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greek_to_latin_transliterator_unit_test
// self-checking bench for the greek to latin transliterator
// ----------------------------------------------------------------------------
// a queue of greek bytes feeds a burst-paced driver; every accepted beat runs
// through a local transliteration predictor that keeps its own held letter
// and queues the expected latin characters; the monitor stalls on a changing
// pattern (plus long hold-offs) and compares every output beat in order
// ----------------------------------------------------------------------------
module greek_to_latin_transliterator_unit_test
  import gtl_pkg::*;
();

  // one input beat: the byte and the end of stream flag
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } greek_item_t;

  // one output beat as predicted
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } latin_beat_t;

  // receiver pacing patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_MOSTLY
  } rx_pace_t;

  // first and second latin character for each byte of the greek range,
  // row 0 is byte 182; a zero second character means none
  localparam logic [0:72][7:0] FIRST_CH = {
    CH_APOS, ".", CH_APOS, CH_APOS, CH_APOS, 8'd187, CH_APOS, 8'd189, CH_APOS,
    CH_APOS, "i",
    "A", "V", "G", "D", "E", "Z", "H", "8", "I", "K",
    "L", "M", "N", "K", "O", "P", "R", 8'd210, "S", "T",
    "Y", "F", "X", "P", "W", "I", "Y",
    "a", "e", "h", "i", "y",
    "a", "v", "g", "d", "e", "z", "h", "8", "i", "k",
    "l", "m", "n", "k", "o", "p", "r", "s", "s", "t",
    "y", "f", "x", "p", "w", "i", "y",
    "o", "y", "w"
  };

  localparam logic [0:72][7:0] SECOND_CH = {
    "A", CH_NONE, "E", "H", "I", CH_NONE, "O", CH_NONE, "Y", "W", CH_APOS,
    {13{CH_NONE}}, "S", {9{CH_NONE}}, "S", CH_NONE, CH_QUOTE, CH_QUOTE,
    {5{CH_APOS}},
    {13{CH_NONE}}, "s", {9{CH_NONE}}, "s", CH_NONE, CH_QUOTE, CH_QUOTE,
    {3{CH_APOS}}
  };

  // bytes that get held back (m, M, n, N) and bytes that can fuse with them
  localparam logic [0:3][7:0] HOLDER_BYTES = {8'd236, 8'd204, 8'd237, 8'd205};
  localparam logic [0:5][7:0] FUSING_BYTES = {
    8'd240, 8'd208, 8'd248, 8'd216, 8'd244, 8'd212
  };

  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned HOLD_OFF_CYCLES = 120;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;   // [7:0] in_byte
  logic       s_tlast = 1'b0;   // end_of_stream
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;          // [7:0] out_char
  logic       m_tlast;          // last_of_run

  greek_item_t bytes_to_send[$];
  latin_beat_t expected_chars[$];
  gtl_held_t   held_letter = HELD_NONE;

  int unsigned beats_in = 0;
  int unsigned errors = 0;
  logic        hold_off = 1'b0;

  greek_to_latin_transliterator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  function automatic logic [7:0] held_char(input gtl_held_t h);
    case (h)
      HELD_M_LC: return "m";
      HELD_M_UC: return "M";
      HELD_N_LC: return "n";
      HELD_N_UC: return "N";
      default:   return CH_NONE;
    endcase
  endfunction

  function automatic gtl_held_t held_code_of(input logic [7:0] c);
    if (c == "m") return HELD_M_LC;
    if (c == "M") return HELD_M_UC;
    if (c == "n") return HELD_N_LC;
    if (c == "N") return HELD_N_UC;
    return HELD_NONE;
  endfunction

  // works out the latin characters for one accepted byte and queues them
  task automatic transliterate_byte(input logic [7:0] b, input logic eos);
    logic [7:0] chars[$];
    logic [7:0] hc;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] fused;
    logic       is_p;
    logic       is_t;
    int         row;
    hc = held_char(held_letter);
    if (b >= TABLE_LOW && b <= TABLE_HIGH) begin
      row    = int'(b) - int'(TABLE_LOW);
      first  = FIRST_CH[row];
      second = SECOND_CH[row];
      is_p   = (first == "p") || (first == "P");
      is_t   = (first == "t") || (first == "T");
      fused  = CH_NONE;
      // case of the fused letter follows the held one, not the follower
      if (held_letter == HELD_M_LC && is_p) fused = "b";
      else if (held_letter == HELD_M_UC && is_p) fused = "B";
      else if (held_letter == HELD_N_LC && is_t) fused = "d";
      else if (held_letter == HELD_N_UC && is_t) fused = "D";
      if (fused != CH_NONE) begin
        chars.push_back(fused);
        if (second != CH_NONE) chars.push_back(second);
        held_letter = HELD_NONE;
      end else begin
        if (hc != CH_NONE) chars.push_back(hc);
        held_letter = held_code_of(first);
        if (held_letter == HELD_NONE) begin
          chars.push_back(first);
          if (second != CH_NONE) chars.push_back(second);
          if (b == QUOTE_A || b == QUOTE_B) chars.push_back(CH_QUOTE);
        end
      end
    end else begin
      // outside the greek range: flush, then the byte unchanged
      if (hc != CH_NONE) chars.push_back(hc);
      chars.push_back(b);
      held_letter = HELD_NONE;
    end
    if (eos) begin
      hc = held_char(held_letter);
      if (hc != CH_NONE) chars.push_back(hc);
      held_letter = HELD_NONE;
    end
    foreach (chars[k]) begin
      expected_chars.push_back('{ch: chars[k], last: (k == chars.size() - 1)});
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: bursts of random length, random gaps
  // --------------------------------------------------------------------------

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    greek_item_t item;
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= 8'd0;
      s_tlast    <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        transliterate_byte(s_tdata, s_tlast);
        beats_in <= beats_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0 || bytes_to_send.size() == 0) begin
          if (gap_left != 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          item = bytes_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.data;
          s_tlast  <= item.eos;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // about a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // long receiver hold-off: the sender keeps offering, the queue fills up
  // --------------------------------------------------------------------------

  int unsigned hold_cycles = 0;
  int unsigned next_hold_at = 40;

  always @(posedge clk) begin
    if (rst) begin
      hold_off     <= 1'b0;
      hold_cycles  = 0;
      next_hold_at = 40;
    end else if (hold_cycles != 0) begin
      hold_cycles--;
      if (hold_cycles == 0) hold_off <= 1'b0;
    end else if (beats_in >= next_hold_at) begin
      hold_off     <= 1'b1;
      hold_cycles  = HOLD_OFF_CYCLES;
      next_hold_at = next_hold_at + 180;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks each output beat, paces m_tready
  // --------------------------------------------------------------------------

  rx_pace_t    rx_pace = RX_ALWAYS;
  int unsigned pace_tick = 0;

  always @(posedge clk) begin
    latin_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual char %h last %b",
                   $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want.ch) begin
            $display("%0t: char mismatch, expected %h actual %h", $time, want.ch, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %b actual %b", $time, want.last, m_tlast);
            errors++;
          end
        end
      end
      // the pattern is redrawn at random on pace_tick so stalls land on every phase
      pace_tick++;
      if (pace_tick % 50 == 0) rx_pace = rx_pace_t'($urandom_range(0, 3));
      if (hold_off) begin
        m_tready <= 1'b0;
      end else begin
        case (rx_pace)
          RX_ALWAYS: m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_tready <= (pace_tick % 4 == 0);
          default:   m_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------

  initial begin
    int unsigned n;
    int unsigned kind;
    logic        eos;
    // directed: range ends, quote bytes, every fusion, failed fusions, flushes
    bytes_to_send.push_back('{data: 8'd0,   eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd255, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd182, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd254, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd192, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd224, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd236, eos: 1'b0});   // m then p
    bytes_to_send.push_back('{data: 8'd240, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd204, eos: 1'b0});   // M then PS
    bytes_to_send.push_back('{data: 8'd216, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd237, eos: 1'b0});   // n then T
    bytes_to_send.push_back('{data: 8'd212, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd205, eos: 1'b0});   // N then t
    bytes_to_send.push_back('{data: 8'd244, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd204, eos: 1'b0});   // M then t, no fusion
    bytes_to_send.push_back('{data: 8'd244, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd236, eos: 1'b0});   // m, m: first one flushed
    bytes_to_send.push_back('{data: 8'd236, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd192, eos: 1'b0});   // four characters
    bytes_to_send.push_back('{data: 8'd237, eos: 1'b0});   // n before a latin byte
    bytes_to_send.push_back('{data: 8'd65,  eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd205, eos: 1'b1});   // held and flushed at once
    bytes_to_send.push_back('{data: 8'd183, eos: 1'b1});   // end with nothing held
    bytes_to_send.push_back('{data: 8'd236, eos: 1'b0});
    bytes_to_send.push_back('{data: 8'd128, eos: 1'b1});

    // random: mostly held letters with fusing or greek followers
    n = 0;
    while (n < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      eos  = ($urandom_range(0, 7) == 0);
      if (kind <= 4) begin
        bytes_to_send.push_back('{data: HOLDER_BYTES[$urandom_range(0, 3)], eos: 1'b0});
        if ($urandom_range(0, 2) != 0)
          bytes_to_send.push_back('{data: FUSING_BYTES[$urandom_range(0, 5)], eos: eos});
        else
          bytes_to_send.push_back('{data: 8'($urandom_range(182, 254)), eos: eos});
        n += 2;
      end else if (kind <= 6) begin
        bytes_to_send.push_back('{data: 8'($urandom_range(182, 254)), eos: eos});
        n += 1;
      end else if (kind == 7) begin
        bytes_to_send.push_back('{data: 8'($urandom_range(0, 255)), eos: eos});
        n += 1;
      end else if (kind == 8) begin
        bytes_to_send.push_back('{data: HOLDER_BYTES[$urandom_range(0, 3)], eos: 1'b0});
        bytes_to_send.push_back('{data: 8'($urandom_range(0, 255)), eos: eos});
        n += 2;
      end else begin
        bytes_to_send.push_back('{data: HOLDER_BYTES[$urandom_range(0, 3)], eos: 1'b1});
        n += 1;
      end
    end
    // close the stream so a held letter is flushed
    bytes_to_send[bytes_to_send.size() - 1].eos = 1'b1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (bytes_to_send.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    // margin that covers the queue depth and the queue register
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* greek_to_latin_transliterator_unit.f */
sv/gtl_pkg.sv
sv/gtl_front.sv
sv/gtl_queue.sv
sv/gtl_back.sv
sv/greek_to_latin_transliterator_unit.sv
tb/greek_to_latin_transliterator_unit_test.sv
